/* src/eqd_pkg.sv */
// eqd_pkg: constants, codes and fixed-point formats shared by the
// equirectangular distance pipeline. No dependencies.
package eqd_pkg;

  // range bounds in units of 1/65536 degree
  localparam logic signed [23:0] LAT_MAX = 24'sd5898240;
  localparam logic signed [23:0] LAT_MIN = -24'sd5898240;
  localparam logic signed [26:0] LON_MIN = -27'sd11796480;
  localparam logic signed [26:0] LON_MAX = 27'sd35389440;

  // degree units to radians: (pi/180) * 2^38, split for 17-bit partial products
  localparam logic [32:0] RAD_K  = 33'd4797524517;
  localparam logic [16:0] RAD_KL = RAD_K[16:0];
  localparam logic [15:0] RAD_KH = RAD_K[32:17];

  localparam logic [33:0] Q30_ONE  = 34'd1 << 30;
  localparam logic [24:0] DIST_MAX = 25'h1FFFFFF;
  localparam logic [15:0] RADIUS_RESET = 16'd6371;

  // horner series for the cosine, divisors and reciprocals scaled by 2^32
  localparam int HORNER_STEPS = 6;
  localparam logic [7:0] HORNER_K [HORNER_STEPS] = '{
    8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
  };
  localparam logic [31:0] HORNER_M [HORNER_STEPS] = '{
    32'((64'd1 << 32) / 64'd132), 32'((64'd1 << 32) / 64'd90),
    32'((64'd1 << 32) / 64'd56),  32'((64'd1 << 32) / 64'd30),
    32'((64'd1 << 32) / 64'd12),  32'((64'd1 << 32) / 64'd2)
  };

  // square of the mean angle, three stages per horner step, final clamp
  localparam int COS_LAT = 1 + 3 * HORNER_STEPS + 1;

  // integer square root: 57-bit radicand, one result bit per stage
  localparam int SQRT_IN_W  = 57;
  localparam int SQRT_OUT_W = 29;
  localparam int SQRT_STEPS = SQRT_OUT_W;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0,
    ERR_LAT1 = 3'd1,
    ERR_LON1 = 3'd2,
    ERR_LAT2 = 3'd3,
    ERR_LON2 = 3'd4
  } err_t;

endpackage

/* src/equirectangular_distance.sv */
// equirectangular_distance: top level of the point-pair distance pipeline.
// Depends on eqd_pkg, eqd_cos and eqd_sqrt.
//
// Usage:
//   Input channel in_valid / in_stall carries one request: two points in
//   signed degrees times 65536. Output channel out_valid / out_stall
//   returns distance (km times 256) and error_code for every request, in
//   order. A range failure gives its code and a zero distance.
//   cfg_write / cfg_data load the earth radius in km; write it only while
//   no request is in flight.
// Stages and throughput:
//   57 register stages: 3 of range check and radian conversion, 20 in
//   the cosine series (three per horner term), 3 for scaling and
//   squares, 29 in the square root (one bit per stage), 2 for radius
//   scaling and rounding. One request enters every cycle while in_stall
//   is low.
// Reset and stall:
//   rst clears all valid bits and sets the radius to 6371 km. When the
//   receiver stalls, a finished result parks in a one-entry skid register;
//   the pipeline freezes only while that register is full, and in_stall
//   mirrors it.
module equirectangular_distance import eqd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] first_latitude,
  input  logic signed [26:0] first_longitude,
  input  logic signed [23:0] second_latitude,
  input  logic signed [26:0] second_longitude,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [24:0]        distance,
  output logic [2:0]         error_code,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data
);

  logic        en;
  logic [15:0] radius;

  // stage 1
  logic signed [24:0] lsum, ldiff;
  logic signed [27:0] odiff;
  err_t        code0;
  logic        v1;
  err_t        code1;
  logic [24:0] asum1, adlat1;
  logic [27:0] adlon1;

  // stage 2
  logic        v2;
  err_t        code2;
  logic [40:0] sm_h, sy_h;
  logic [41:0] sm_l, sy_l;
  logic [43:0] sx_h;
  logic [44:0] sx_l;

  // stage 3
  logic [57:0] sm_full, sy_full;
  logic [60:0] sx_full;
  logic        v3;
  err_t        code3;
  logic [30:0] mean_r3;
  logic [31:0] y30_3;
  logic [33:0] dl30_3;

  // cosine delay line
  logic [30:0] cosine;
  logic        cv   [COS_LAT];
  err_t        ccode[COS_LAT];
  logic [31:0] cy30 [COS_LAT];
  logic [33:0] cdl30[COS_LAT];

  // scaling and squares
  logic        vx1, vx2, vx3;
  err_t        codex1, codex2, codex3;
  logic [47:0] px_h, px_l;
  logic [31:0] y30_x1;
  logic [64:0] px_full;
  logic [27:0] x24;
  logic [25:0] y24;
  logic [55:0] xx;
  logic [51:0] yy;
  logic [SQRT_IN_W-1:0] rad4;

  // square root delay line
  logic [SQRT_OUT_W-1:0] root;
  logic  sv   [SQRT_STEPS];
  err_t  scode[SQRT_STEPS];

  // radius scaling and output
  logic        vd1;
  err_t        coded1;
  logic [44:0] prod;
  logic [45:0] rnd;
  logic [29:0] dq;
  logic        pv;
  err_t        pcode;
  logic [24:0] pdist;
  logic        skid_v;
  err_t        skid_code;
  logic [24:0] skid_dist;

  // pipeline advances while the skid register is empty
  assign en       = !skid_v;
  assign in_stall = skid_v;

  // radius register
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_write) begin
      radius <= cfg_data;
    end
  end

  // range check, first failure wins
  always_comb begin
    priority if (first_latitude < LAT_MIN || first_latitude > LAT_MAX) begin
      code0 = ERR_LAT1;
    end else if (first_longitude < LON_MIN || first_longitude > LON_MAX) begin
      code0 = ERR_LON1;
    end else if (second_latitude < LAT_MIN || second_latitude > LAT_MAX) begin
      code0 = ERR_LAT2;
    end else if (second_longitude < LON_MIN || second_longitude > LON_MAX) begin
      code0 = ERR_LON2;
    end else begin
      code0 = ERR_NONE;
    end
  end

  // sums and differences of the angles
  assign lsum  = {first_latitude[23], first_latitude}
               + {second_latitude[23], second_latitude};
  assign ldiff = {second_latitude[23], second_latitude}
               - {first_latitude[23], first_latitude};
  assign odiff = {second_longitude[26], second_longitude}
               - {first_longitude[26], first_longitude};

  always_ff @(posedge clk) begin
    if (en) begin
      code1  <= code0;
      asum1  <= lsum[24]  ? 25'(-lsum)  : 25'(lsum);
      adlat1 <= ldiff[24] ? 25'(-ldiff) : 25'(ldiff);
      adlon1 <= odiff[27] ? 28'(-odiff) : 28'(odiff);
    end
  end

  // radian conversion partial products
  always_ff @(posedge clk) begin
    if (en) begin
      code2 <= code1;
      sm_h  <= 41'(asum1)  * 41'(RAD_KH);
      sm_l  <= 42'(asum1)  * 42'(RAD_KL);
      sy_h  <= 41'(adlat1) * 41'(RAD_KH);
      sy_l  <= 42'(adlat1) * 42'(RAD_KL);
      sx_h  <= 44'(adlon1) * 44'(RAD_KH);
      sx_l  <= 45'(adlon1) * 45'(RAD_KL);
    end
  end

  // combine partial products into Q30 radians
  assign sm_full = {sm_h, 17'b0} + 58'(sm_l);
  assign sy_full = {sy_h, 17'b0} + 58'(sy_l);
  assign sx_full = {sx_h, 17'b0} + 61'(sx_l);

  always_ff @(posedge clk) begin
    if (en) begin
      code3   <= code2;
      mean_r3 <= sm_full[55:25];
      y30_3   <= sy_full[55:24];
      dl30_3  <= sx_full[57:24];
    end
  end

  eqd_cos u_cos (
    .clk    (clk),
    .en     (en),
    .angle  (mean_r3),
    .cosine (cosine)
  );

  // side data follows the cosine series
  always_ff @(posedge clk) begin
    if (en) begin
      ccode[0] <= code3;
      cy30[0]  <= y30_3;
      cdl30[0] <= dl30_3;
      for (int i = 1; i < COS_LAT; i++) begin
        ccode[i] <= ccode[i-1];
        cy30[i]  <= cy30[i-1];
        cdl30[i] <= cdl30[i-1];
      end
    end
  end

  // longitude difference times cosine, split in two partial products
  assign px_full = {px_h, 17'b0} + 65'(px_l);
  assign x24     = px_full[63:36];
  assign y24     = y30_x1[31:6];

  always_ff @(posedge clk) begin
    if (en) begin
      codex1 <= ccode[COS_LAT-1];
      y30_x1 <= cy30[COS_LAT-1];
      px_h   <= 48'(cdl30[COS_LAT-1][33:17]) * 48'(cosine);
      px_l   <= 48'(cdl30[COS_LAT-1][16:0])  * 48'(cosine);
      codex2 <= codex1;
      codex3 <= codex2;
      xx     <= 56'(x24) * 56'(x24);
      yy     <= 52'(y24) * 52'(y24);
      rad4   <= SQRT_IN_W'(xx) + SQRT_IN_W'(yy);
    end
  end

  eqd_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (rad4),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      scode[0] <= codex3;
      for (int i = 1; i < SQRT_STEPS; i++) begin
        scode[i] <= scode[i-1];
      end
    end
  end

  // scale by the radius, round half up, saturate; zero on a range failure
  assign rnd = 46'(prod) + (46'd1 << 15);
  assign dq  = rnd[45:16];

  always_ff @(posedge clk) begin
    if (en) begin
      coded1 <= scode[SQRT_STEPS-1];
      prod   <= 45'(root) * 45'(radius);
      pcode  <= coded1;
      if (coded1 != ERR_NONE) begin
        pdist <= '0;
      end else if (dq > 30'(DIST_MAX)) begin
        pdist <= DIST_MAX;
      end else begin
        pdist <= dq[24:0];
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      vx1 <= 1'b0;
      vx2 <= 1'b0;
      vx3 <= 1'b0;
      vd1 <= 1'b0;
      pv  <= 1'b0;
      for (int i = 0; i < COS_LAT; i++) begin
        cv[i] <= 1'b0;
      end
      for (int i = 0; i < SQRT_STEPS; i++) begin
        sv[i] <= 1'b0;
      end
    end else if (en) begin
      v1    <= in_valid;
      v2    <= v1;
      v3    <= v2;
      cv[0] <= v3;
      for (int i = 1; i < COS_LAT; i++) begin
        cv[i] <= cv[i-1];
      end
      vx1   <= cv[COS_LAT-1];
      vx2   <= vx1;
      vx3   <= vx2;
      sv[0] <= vx3;
      for (int i = 1; i < SQRT_STEPS; i++) begin
        sv[i] <= sv[i-1];
      end
      vd1   <= sv[SQRT_STEPS-1];
      pv    <= vd1;
    end
  end

  // skid register holds a result the receiver has not taken
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (!skid_v) begin
      if (pv && out_stall) begin
        skid_v    <= 1'b1;
        skid_code <= pcode;
        skid_dist <= pdist;
      end
    end else if (!out_stall) begin
      skid_v <= 1'b0;
    end
  end

  assign out_valid  = skid_v || pv;
  assign distance   = skid_v ? skid_dist : pdist;
  assign error_code = skid_v ? skid_code : pcode;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_NONE |-> distance == '0)
    else $error("nonzero distance with an error code");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(pv && out_stall))
    else $error("skid filled without a stalled result");

  a_req_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> v1)
    else $error("accepted request missing from first stage");
`endif

endmodule

/* src/eqd_cos.sv */
// eqd_cos: pipelined Q30 cosine of the mean latitude by a horner series.
// Depends on eqd_pkg.
module eqd_cos import eqd_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] angle,
  output logic [30:0] cosine
);

  logic [31:0] r2_q;
  logic [62:0] a_prod [HORNER_STEPS];
  logic [31:0] a_r2   [HORNER_STEPS];
  logic [31:0] b_p    [HORNER_STEPS];
  logic [63:0] b_qm   [HORNER_STEPS];
  logic [31:0] b_r2   [HORNER_STEPS];
  logic signed [33:0] c_t [HORNER_STEPS];
  logic [31:0] c_r2   [HORNER_STEPS];
  logic [61:0] sq;
  logic signed [33:0] t_last;

  // square of the angle, back to Q30
  assign sq = 62'(angle) * 62'(angle);

  always_ff @(posedge clk) begin
    if (en) begin
      r2_q <= sq[61:30];
    end
  end

  for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_step
    logic [31:0] r2_in;
    logic [30:0] t_in;
    logic [31:0] q0;
    logic [39:0] qk;
    logic [39:0] rem;
    logic [33:0] q;

    if (j == 0) begin : g_first
      assign r2_in = r2_q;
      assign t_in  = Q30_ONE[30:0];
    end else begin : g_rest
      assign r2_in = c_r2[j-1];
      assign t_in  = c_t[j-1][30:0];
    end

    // quotient by the constant divisor: reciprocal estimate plus one correction
    assign q0  = b_qm[j][63:32];
    assign qk  = 40'(q0) * 40'(HORNER_K[j]);
    assign rem = 40'(b_p[j]) - qk;
    assign q   = 34'(q0) + ((rem >= 40'(HORNER_K[j])) ? 34'd1 : 34'd0);

    always_ff @(posedge clk) begin
      if (en) begin
        a_prod[j] <= 63'(r2_in) * 63'(t_in);
        a_r2[j]   <= r2_in;
        b_p[j]    <= a_prod[j][61:30];
        b_qm[j]   <= 64'(a_prod[j][61:30]) * 64'(HORNER_M[j]);
        b_r2[j]   <= a_r2[j];
        c_t[j]    <= $signed(Q30_ONE) - $signed(q);
        c_r2[j]   <= b_r2[j];
      end
    end
  end

  // clamp to 0..1
  assign t_last = c_t[HORNER_STEPS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (t_last < 0) begin
        cosine <= '0;
      end else if (t_last > $signed(Q30_ONE)) begin
        cosine <= Q30_ONE[30:0];
      end else begin
        cosine <= t_last[30:0];
      end
    end
  end

endmodule

/* src/eqd_sqrt.sv */
// eqd_sqrt: pipelined floor square root, one result bit per stage.
// Depends on eqd_pkg.
module eqd_sqrt import eqd_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [SQRT_IN_W-1:0]  radicand,
  output logic [SQRT_OUT_W-1:0] root
);

  localparam int RW = SQRT_IN_W + 1;

  logic [SQRT_IN_W-1:0] rem_q [1:SQRT_STEPS];
  logic [RW-1:0]        res_q [1:SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQRT_STEPS - 1 - i));
    logic [SQRT_IN_W-1:0] rem_in;
    logic [RW-1:0]        res_in;
    logic [RW-1:0]        trial;

    if (i == 0) begin : g_first
      assign rem_in = radicand;
      assign res_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[i];
      assign res_in = res_q[i];
    end

    assign trial = res_in + BIT;

    // restoring step: subtract the trial value where it fits
    always_ff @(posedge clk) begin
      if (en) begin
        if (RW'(rem_in) >= trial) begin
          rem_q[i+1] <= rem_in - trial[SQRT_IN_W-1:0];
          res_q[i+1] <= (res_in >> 1) + BIT;
        end else begin
          rem_q[i+1] <= rem_in;
          res_q[i+1] <= res_in >> 1;
        end
      end
    end
  end

  assign root = res_q[SQRT_STEPS][SQRT_OUT_W-1:0];

endmodule
